/* design/boundary_blend_pole_grid_macros.svh */
// assertion macros for the boundary blend pole grid
`ifndef BOUNDARY_BLEND_POLE_GRID_MACROS_SVH
`define BOUNDARY_BLEND_POLE_GRID_MACROS_SVH

// same-cycle implication
`define BBPG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bbpg assertion failed");

// next-cycle implication
`define BBPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bbpg assertion failed");

`endif

/* design/bbpg_pkg.sv */
// shared types, constants and functions of the boundary blend pole grid
`default_nettype none
package bbpg_pkg;

	localparam int MAX_POLES  = 16;
	localparam int IDX_W      = $clog2(MAX_POLES);
	localparam int MEM_DEPTH  = 4 * MAX_POLES;
	localparam int ADDR_W     = IDX_W + 2;
	localparam int LANES      = 4;
	localparam int LANE_W     = 33;
	localparam int T_W        = 40;
	localparam int NUM_W      = 47;
	localparam int DIV_DW     = 50;
	localparam int DIV_VW     = 25;
	localparam int DIV_STEPS  = DIV_DW;
	localparam int CNT_W      = $clog2(DIV_STEPS + 1);
	localparam int BIG_W      = 51;

	localparam logic [23:0] UNIT_WEIGHT = 24'h010000;
	localparam logic [23:0] MAX_WEIGHT  = 24'hFFFFFF;

	localparam logic signed [BIG_W-1:0] SAT_HI = 51'sh7FFFFFFF;
	localparam logic signed [BIG_W-1:0] SAT_LO = -51'sh80000000;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_RANGE     = 2'd1;
	localparam logic [1:0] ST_ZERO_BASE = 2'd2;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [1:0] CRV_1 = 2'd0;
	localparam logic [1:0] CRV_2 = 2'd1;
	localparam logic [1:0] CRV_3 = 2'd2;
	localparam logic [1:0] CRV_4 = 2'd3;

	localparam logic [1:0] LANE_X = 2'd0;
	localparam logic [1:0] LANE_Y = 2'd1;
	localparam logic [1:0] LANE_Z = 2'd2;
	localparam logic [1:0] LANE_W_IDX = 2'd3;

	localparam logic [1:0] REG_NUM_U     = 2'd0;
	localparam logic [1:0] REG_NUM_V     = 2'd1;
	localparam logic [1:0] REG_FILL_MODE = 2'd2;
	localparam logic [1:0] REG_RATIONAL  = 2'd3;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_RD0   = 9'b000000010,
		S_RD1   = 9'b000000100,
		S_RD2   = 9'b000001000,
		S_MUL1  = 9'b000010000,
		S_MUL2  = 9'b000100000,
		S_LOAD  = 9'b001000000,
		S_DIV   = 9'b010000000,
		S_FIN   = 9'b100000000
	} state_t;

	typedef struct packed {
		logic load;
		logic take;
		logic rd0;
		logic rd1;
		logic rd2;
		logic mul1;
		logic mul2;
		logic div_load;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} stat_t;

	typedef struct packed {
		logic [4:0] num_u;
		logic [4:0] num_v;
		logic       fill_mode;
		logic       rational;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic [23:0]        w;
	} pt_t;

	function automatic logic signed [LANE_W-1:0] pt_lane(input pt_t p, input logic [1:0] k);
		logic signed [LANE_W-1:0] v;
		case (k)
			LANE_X:  v = {p.x[31], p.x};
			LANE_Y:  v = {p.y[31], p.y};
			LANE_Z:  v = {p.z[31], p.z};
			default: v = {9'b0, p.w};
		endcase
		return v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [BIG_W-1:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI) begin
			r = 32'sh7FFFFFFF;
		end else if (v < SAT_LO) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic [4:0] clamp_size(input logic [4:0] n);
		logic [4:0] r;
		if (n < 5'd2) begin
			r = 5'd2;
		end else if (n > 5'(MAX_POLES)) begin
			r = 5'(MAX_POLES);
		end else begin
			r = n;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* design/bbpg_div.sv */
// four-lane restoring divider, one quotient bit per cycle
`default_nettype none
module bbpg_div (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire logic [bbpg_pkg::LANES-1:0][bbpg_pkg::DIV_DW-1:0] dividend,
	input  wire logic [bbpg_pkg::DIV_VW-1:0] divisor,
	output logic [bbpg_pkg::LANES-1:0][bbpg_pkg::DIV_DW-1:0] quotient,
	output logic done
);

	logic                          run_q;
	logic [bbpg_pkg::CNT_W-1:0]    cnt_q;
	logic [bbpg_pkg::LANES-1:0][bbpg_pkg::DIV_DW-1:0] quo_q, quo_nxt;
	logic [bbpg_pkg::LANES-1:0][bbpg_pkg::DIV_VW-1:0] rem_q, rem_nxt;
	logic [bbpg_pkg::LANES-1:0][bbpg_pkg::DIV_VW:0]   sh, diff;

	always_comb begin
		for (int i = 0; i < bbpg_pkg::LANES; i++) begin
			sh[i]   = {rem_q[i], quo_q[i][bbpg_pkg::DIV_DW-1]};
			diff[i] = sh[i] - {1'b0, divisor};
			if (sh[i] >= {1'b0, divisor}) begin
				rem_nxt[i] = diff[i][bbpg_pkg::DIV_VW-1:0];
				quo_nxt[i] = {quo_q[i][bbpg_pkg::DIV_DW-2:0], 1'b1};
			end else begin
				rem_nxt[i] = sh[i][bbpg_pkg::DIV_VW-1:0];
				quo_nxt[i] = {quo_q[i][bbpg_pkg::DIV_DW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (load) begin
			run_q <= 1'b1;
			cnt_q <= bbpg_pkg::CNT_W'(bbpg_pkg::DIV_STEPS);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == bbpg_pkg::CNT_W'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign quotient = quo_q;
	assign done     = run_q && (cnt_q == bbpg_pkg::CNT_W'(1));

endmodule
`default_nettype wire

/* design/bbpg_datapath.sv */
// boundary store, blend arithmetic and result registers
`default_nettype none
module bbpg_datapath (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire bbpg_pkg::cmd_t cmd,
	output bbpg_pkg::stat_t stat,
	input  wire bbpg_pkg::cfg_t cfg,
	input  wire logic [1:0]  curve_sel,
	input  wire logic [3:0]  point_index,
	input  wire logic signed [31:0] in_x,
	input  wire logic signed [31:0] in_y,
	input  wire logic signed [31:0] in_z,
	input  wire logic [23:0] in_weight,
	input  wire logic [3:0]  grid_row,
	input  wire logic [3:0]  grid_col,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [23:0] out_weight,
	output logic [1:0]  status,
	output logic        done
);

	bbpg_pkg::pt_t mem_q [bbpg_pkg::MEM_DEPTH];
	bbpg_pkg::pt_t rda_q, rdb_q, a_q, b_q, e_q, f_q, b0_q;
	logic [bbpg_pkg::ADDR_W-1:0] ra, rb;
	logic [3:0]  r_q, c_q;
	logic [23:0] base_q;
	logic [47:0] prod_q;
	logic [bbpg_pkg::DIV_DW-1:0] wdiv_q;
	logic [bbpg_pkg::DIV_VW-1:0] d_q;
	logic [bbpg_pkg::LANES-1:0][bbpg_pkg::T_W-1:0]   t1_q, t2_q;
	logic [bbpg_pkg::LANES-1:0][bbpg_pkg::NUM_W-1:0] num_q;
	logic [bbpg_pkg::LANES-1:0] neg_q;
	logic [bbpg_pkg::LANES-1:0][bbpg_pkg::DIV_DW-1:0] div_in, quo;

	logic [4:0] nu, nv;
	logic [3:0] nu1, nv1;
	logic [7:0] kk;
	logic signed [5:0] cva, cc, rva, rr, nu1s, nv1s;

	logic signed [31:0] ox, oy, oz;
	logic [23:0] ow;
	logic [1:0]  ost;
	logic signed [bbpg_pkg::BIG_W-1:0] bq [bbpg_pkg::LANES];
	logic signed [31:0] pv [bbpg_pkg::LANES];
	logic oor, col0, colz, row0, rowz;

	always_comb begin
		nu   = bbpg_pkg::clamp_size(cfg.num_u);
		nv   = bbpg_pkg::clamp_size(cfg.num_v);
		nu1  = 4'(nu - 5'd1);
		nv1  = 4'(nv - 5'd1);
		kk   = nu1 * nv1;
		nu1s = $signed({2'b00, nu1});
		nv1s = $signed({2'b00, nv1});
		cc   = $signed({2'b00, c_q});
		rr   = $signed({2'b00, r_q});
		cva  = nv1s - cc;
		rva  = nu1s - rr;
	end

	// boundary store: one write port, two registered read ports
	always_comb begin
		if (cmd.rd0) begin
			ra = {bbpg_pkg::CRV_1, r_q};
			rb = {bbpg_pkg::CRV_3, r_q};
		end else if (cmd.rd1) begin
			ra = {bbpg_pkg::CRV_2, c_q};
			rb = {bbpg_pkg::CRV_4, c_q};
		end else begin
			ra = {bbpg_pkg::CRV_2, 4'd0};
			rb = {bbpg_pkg::CRV_1, 4'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem_q[{curve_sel, point_index}] <= {in_x, in_y, in_z, in_weight};
		end
		rda_q <= mem_q[ra];
		rdb_q <= mem_q[rb];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			r_q <= grid_row;
			c_q <= grid_col;
		end
		if (cmd.rd1) begin
			a_q <= rda_q;
			e_q <= rdb_q;
		end
		if (cmd.rd2) begin
			b_q <= rda_q;
			f_q <= rdb_q;
		end
		if (cmd.mul1) begin
			b0_q   <= rda_q;
			base_q <= rdb_q.w;
			prod_q <= a_q.w * b_q.w;
			for (int k = 0; k < bbpg_pkg::LANES; k++) begin
				t1_q[k] <= cva * bbpg_pkg::pt_lane(a_q, 2'(k))
					+ cc * bbpg_pkg::pt_lane(e_q, 2'(k));
				t2_q[k] <= rr * bbpg_pkg::pt_lane(b_q, 2'(k))
					+ rva * bbpg_pkg::pt_lane(f_q, 2'(k));
			end
		end
		if (cmd.mul2) begin
			for (int k = 0; k < bbpg_pkg::LANES; k++) begin
				num_q[k] <= nu1s * $signed(t1_q[k]) + nv1s * $signed(t2_q[k])
					+ $signed({39'b0, kk});
			end
			wdiv_q <= {1'b0, prod_q, 1'b0} + {26'b0, base_q};
			if (cfg.fill_mode) begin
				d_q <= {base_q, 1'b0};
			end else begin
				d_q <= {16'b0, kk, 1'b0};
			end
		end
		if (cmd.div_load) begin
			for (int k = 0; k < bbpg_pkg::LANES; k++) begin
				neg_q[k] <= num_q[k][bbpg_pkg::NUM_W-1];
			end
		end
	end

	// floor division of a negative numerator goes through (-n + d - 1) / d
	always_comb begin
		for (int k = 0; k < bbpg_pkg::LANES; k++) begin
			if (num_q[k][bbpg_pkg::NUM_W-1]) begin
				div_in[k] = {3'b0, ~num_q[k]} + {25'b0, d_q};
			end else begin
				div_in[k] = {3'b0, num_q[k]};
			end
		end
		if (cfg.fill_mode) begin
			div_in[bbpg_pkg::LANES-1] = wdiv_q;
		end
	end

	bbpg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.div_load),
		.dividend (div_in),
		.divisor  (d_q),
		.quotient (quo),
		.done     (stat.div_done)
	);

	always_comb begin
		oor  = ({1'b0, r_q} >= nu) || ({1'b0, c_q} >= nv);
		col0 = (c_q == 4'd0);
		colz = (c_q == nv1);
		row0 = (r_q == 4'd0);
		rowz = (r_q == nu1);
		for (int k = 0; k < bbpg_pkg::LANES; k++) begin
			bq[k] = neg_q[k] ? -$signed({1'b0, quo[k]}) : $signed({1'b0, quo[k]});
			if (cfg.fill_mode) begin
				pv[k] = bbpg_pkg::sat32(bbpg_pkg::BIG_W'(bbpg_pkg::pt_lane(a_q, 2'(k)))
					+ bbpg_pkg::BIG_W'(bbpg_pkg::pt_lane(b_q, 2'(k)))
					- bbpg_pkg::BIG_W'(bbpg_pkg::pt_lane(b0_q, 2'(k))));
			end else if (col0) begin
				pv[k] = 32'(bbpg_pkg::pt_lane(a_q, 2'(k)));
			end else if (colz) begin
				pv[k] = 32'(bbpg_pkg::pt_lane(e_q, 2'(k)));
			end else if (row0) begin
				pv[k] = 32'(bbpg_pkg::pt_lane(f_q, 2'(k)));
			end else if (rowz) begin
				pv[k] = 32'(bbpg_pkg::pt_lane(b_q, 2'(k)));
			end else begin
				pv[k] = bbpg_pkg::sat32(bq[k]);
			end
		end
		ost = bbpg_pkg::ST_OK;
		if (!cfg.rational) begin
			ow = bbpg_pkg::UNIT_WEIGHT;
		end else if (cfg.fill_mode) begin
			if (base_q == 24'd0) begin
				ow  = bbpg_pkg::MAX_WEIGHT;
				ost = bbpg_pkg::ST_ZERO_BASE;
			end else if (quo[bbpg_pkg::LANES-1] > {26'b0, bbpg_pkg::MAX_WEIGHT}) begin
				ow = bbpg_pkg::MAX_WEIGHT;
			end else begin
				ow = quo[bbpg_pkg::LANES-1][23:0];
			end
		end else if (col0 || colz || row0 || rowz) begin
			ow = pv[bbpg_pkg::LANE_W_IDX][23:0];
		end else if (bq[bbpg_pkg::LANES-1] < 0) begin
			ow = 24'd0;
		end else if (bq[bbpg_pkg::LANES-1] > $signed({27'b0, bbpg_pkg::MAX_WEIGHT})) begin
			ow = bbpg_pkg::MAX_WEIGHT;
		end else begin
			ow = bq[bbpg_pkg::LANES-1][23:0];
		end
		ox = pv[bbpg_pkg::LANE_X];
		oy = pv[bbpg_pkg::LANE_Y];
		oz = pv[bbpg_pkg::LANE_Z];
		if (oor) begin
			ox  = '0;
			oy  = '0;
			oz  = '0;
			ow  = '0;
			ost = bbpg_pkg::ST_RANGE;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_x      <= ox;
			out_y      <= oy;
			out_z      <= oz;
			out_weight <= ow;
			status     <= ost;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.fin;
		end
	end

endmodule
`default_nettype wire

/* design/bbpg_ctrl.sv */
// sequencing state machine for loads and queries
`default_nettype none
module bbpg_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic req_type,
	input  wire bbpg_pkg::stat_t stat,
	output bbpg_pkg::cmd_t cmd,
	output logic busy
);

	bbpg_pkg::state_t state_q, state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			bbpg_pkg::S_IDLE: begin
				if (start) begin
					if (req_type == bbpg_pkg::REQ_QUERY) begin
						cmd.take  = 1'b1;
						state_nxt = bbpg_pkg::S_RD0;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			bbpg_pkg::S_RD0: begin
				cmd.rd0   = 1'b1;
				state_nxt = bbpg_pkg::S_RD1;
			end
			bbpg_pkg::S_RD1: begin
				cmd.rd1   = 1'b1;
				state_nxt = bbpg_pkg::S_RD2;
			end
			bbpg_pkg::S_RD2: begin
				cmd.rd2   = 1'b1;
				state_nxt = bbpg_pkg::S_MUL1;
			end
			bbpg_pkg::S_MUL1: begin
				cmd.mul1  = 1'b1;
				state_nxt = bbpg_pkg::S_MUL2;
			end
			bbpg_pkg::S_MUL2: begin
				cmd.mul2  = 1'b1;
				state_nxt = bbpg_pkg::S_LOAD;
			end
			bbpg_pkg::S_LOAD: begin
				cmd.div_load = 1'b1;
				state_nxt    = bbpg_pkg::S_DIV;
			end
			bbpg_pkg::S_DIV: begin
				if (stat.div_done) begin
					state_nxt = bbpg_pkg::S_FIN;
				end
			end
			bbpg_pkg::S_FIN: begin
				cmd.fin   = 1'b1;
				state_nxt = bbpg_pkg::S_IDLE;
			end
			default: begin
				state_nxt = bbpg_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbpg_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != bbpg_pkg::S_IDLE);

endmodule
`default_nettype wire

/* design/boundary_blend_pole_grid.sv */
// top level: register port, controller and datapath of the pole grid
//
// channel   handshake              payload
// command   start & !busy          req_type curve_sel point_index in_x/y/z in_weight grid_row/col
// result    done, one cycle        out_x out_y out_z out_weight status
// config    psel penable pwrite    paddr[3:2] selects num_u num_v fill_mode rational
//
// a load leaves busy low and the next command may follow at once
// a query runs three boundary reads, two multiply steps, a divider load, then a
// restoring division, and busy stays high until its result is registered
// done rises in the first idle cycle, so the next command can be taken alongside it
// reset clears the controller, config registers, divider and done; the boundary store is undefined until loaded
`default_nettype none
`include "boundary_blend_pole_grid_macros.svh"
module boundary_blend_pole_grid (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire logic req_type,
	input  wire logic [1:0]  curve_sel,
	input  wire logic [3:0]  point_index,
	input  wire logic signed [31:0] in_x,
	input  wire logic signed [31:0] in_y,
	input  wire logic signed [31:0] in_z,
	input  wire logic [23:0] in_weight,
	input  wire logic [3:0]  grid_row,
	input  wire logic [3:0]  grid_col,
	output logic done,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [23:0] out_weight,
	output logic [1:0]  status,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	bbpg_pkg::cfg_t  cfg_q;
	bbpg_pkg::cmd_t  cmd;
	bbpg_pkg::stat_t stat;
	logic            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_u     <= 5'd2;
			cfg_q.num_v     <= 5'd2;
			cfg_q.fill_mode <= 1'b0;
			cfg_q.rational  <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				bbpg_pkg::REG_NUM_U:     cfg_q.num_u     <= pwdata[4:0];
				bbpg_pkg::REG_NUM_V:     cfg_q.num_v     <= pwdata[4:0];
				bbpg_pkg::REG_FILL_MODE: cfg_q.fill_mode <= pwdata[0];
				bbpg_pkg::REG_RATIONAL:  cfg_q.rational  <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			bbpg_pkg::REG_NUM_U:     prdata = {27'b0, cfg_q.num_u};
			bbpg_pkg::REG_NUM_V:     prdata = {27'b0, cfg_q.num_v};
			bbpg_pkg::REG_FILL_MODE: prdata = {31'b0, cfg_q.fill_mode};
			bbpg_pkg::REG_RATIONAL:  prdata = {31'b0, cfg_q.rational};
			default:                 prdata = '0;
		endcase
	end

	bbpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy)
	);

	bbpg_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg         (cfg_q),
		.curve_sel   (curve_sel),
		.point_index (point_index),
		.in_x        (in_x),
		.in_y        (in_y),
		.in_z        (in_z),
		.in_weight   (in_weight),
		.grid_row    (grid_row),
		.grid_col    (grid_col),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z),
		.out_weight  (out_weight),
		.status      (status),
		.done        (done)
	);

	`BBPG_ASSERT_IMPL(a_done_idle, clk, arst_n, done, !busy)
	`BBPG_ASSERT_NEXT(a_query_busy, clk, arst_n, start && !busy && req_type, busy)
	`BBPG_ASSERT_NEXT(a_load_silent, clk, arst_n, start && !busy && !req_type, !done && !busy)
	`BBPG_ASSERT_IMPL(a_range_zero, clk, arst_n, done && (status == bbpg_pkg::ST_RANGE), (out_x == 32'sd0) && (out_weight == 24'd0))

endmodule
`default_nettype wire
